@@ rtl/ray_disk_intersect_macros.svh @@
// ============================================================================
// ray_disk_intersect_macros
// assertion shorthands used by the ray/cap intersection top level
// ============================================================================
`ifndef RAY_DISK_INTERSECT_MACROS_SVH
`define RAY_DISK_INTERSECT_MACROS_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define RDI_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on clk, off while rst_n is low
`define RDI_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/rdi_pkg.sv @@
// ============================================================================
// rdi_pkg
// shared types, constants and helpers for the ray/cap intersection pipeline
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

package rdi_pkg;

    // saturation limits of a 32-bit signed value
    localparam logic signed [31:0] S32_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;

    // register indexes of the configuration channel
    typedef enum logic [2:0] {
        REG_CENTER_X = 3'd0,
        REG_CENTER_Y = 3'd1,
        REG_CENTER_Z = 3'd2,
        REG_AXIS_X   = 3'd3,
        REG_AXIS_Y   = 3'd4,
        REG_AXIS_Z   = 3'd5,
        REG_RADIUS   = 3'd6,
        REG_PAR_THR  = 3'd7
    } reg_idx_t;

    // one ray as it enters the pipeline
    typedef struct packed {
        logic [2:0][31:0] org;
        logic [2:0][31:0] dir;
        logic [31:0]      t_min;
        logic [31:0]      t_max;
    } ray_t;

    // cap geometry seen by the pipeline
    typedef struct packed {
        logic [2:0][31:0] center;
        logic [2:0][17:0] axis;
        logic [15:0]      par_thr;
        logic [62:0]      lim;      // radius squared plus one lsb
    } cfg_t;

    // side information carried alongside the divider
    typedef struct packed {
        ray_t ray;
        logic neg;                  // quotient sign
        logic miss;                 // ray already rejected
    } div_side_t;

    // clamp a wide signed value into 32 bits
    function automatic logic [31:0] sat32(input logic signed [71:0] v);
        logic [31:0] r;
        if (v > 72'(S32_MAX)) begin
            r = S32_MAX;
        end
        else if (v < 72'(S32_MIN)) begin
            r = S32_MIN;
        end
        else begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

@@ rtl/rdi_front.sv @@
// ============================================================================
// rdi_front
// plane dot products, parallel test and divider operand preparation
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module rdi_front #(
    parameter int FRAC_BITS = 16
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire rdi_pkg::cfg_t      cfg,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire rdi_pkg::ray_t      in_ray,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output rdi_pkg::div_side_t      out_side,
    output logic [52:0]             out_num_mag,
    output logic [31:0]             out_den_mag
);

    localparam int NST = 4;

    logic [NST-1:0] vld_reg;
    logic [NST-1:0] adv;
    logic [NST-1:0] vld_src;

    // stage registers
    rdi_pkg::ray_t      ray0_reg, ray1_reg, ray2_reg;
    logic signed [32:0] diff_reg [3];
    logic signed [32:0] diff_next [3];
    logic signed [49:0] pd_reg [3];
    logic signed [49:0] pd_next [3];
    logic signed [50:0] pn_reg [3];
    logic signed [50:0] pn_next [3];
    logic signed [31:0] dn_reg, dn_next;
    logic signed [52:0] num_reg, num_next;
    logic signed [51:0] sum_d;
    rdi_pkg::div_side_t side_reg, side_next;
    logic [52:0]        nmag_reg, nmag_next;
    logic [31:0]        dmag_reg, dmag_next;

    // ready chain, a stage moves when empty or when the next one moves
    assign adv[NST-1] = ~vld_reg[NST-1] | out_ready;
    genvar k;
    generate
        for (k = 0; k < NST - 1; k++) begin : g_adv
            assign adv[k] = ~vld_reg[k] | adv[k+1];
        end
    endgenerate
    assign vld_src  = {vld_reg[NST-2:0], in_valid};
    assign in_ready = adv[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= (adv & vld_src) | (~adv & vld_reg);
        end
    end

    // stage 0: center minus origin
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            diff_next[i] = 33'($signed(cfg.center[i])) - 33'($signed(in_ray.org[i]));
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv[0])
        begin
            ray0_reg <= in_ray;
            for (int i = 0; i < 3; i++)
            begin
                diff_reg[i] <= diff_next[i];
            end
        end
    end

    // stage 1: axis products
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            pd_next[i] = $signed(cfg.axis[i]) * $signed(ray0_reg.dir[i]);
            pn_next[i] = $signed(cfg.axis[i]) * diff_reg[i];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv[1])
        begin
            ray1_reg <= ray0_reg;
            for (int i = 0; i < 3; i++)
            begin
                pd_reg[i] <= pd_next[i];
                pn_reg[i] <= pn_next[i];
            end
        end
    end

    // stage 2: sums, direction dot rescaled and saturated
    always_comb
    begin
        sum_d    = 52'(pd_reg[0]) + 52'(pd_reg[1]) + 52'(pd_reg[2]);
        dn_next  = $signed(rdi_pkg::sat32(72'(sum_d >>> FRAC_BITS)));
        num_next = 53'(pn_reg[0]) + 53'(pn_reg[1]) + 53'(pn_reg[2]);
    end

    always_ff @(posedge clk)
    begin
        if (adv[2])
        begin
            ray2_reg <= ray1_reg;
            dn_reg   <= dn_next;
            num_reg  <= num_next;
        end
    end

    // stage 3: magnitudes, quotient sign and parallel test
    always_comb
    begin
        nmag_next      = num_reg[52] ? 53'(-num_reg) : 53'(num_reg);
        dmag_next      = dn_reg[31] ? 32'(-dn_reg) : 32'(dn_reg);
        side_next.ray  = ray2_reg;
        side_next.neg  = num_reg[52] ^ dn_reg[31];
        side_next.miss = (dmag_next == 32'd0) || (dmag_next < {16'd0, cfg.par_thr});
    end

    always_ff @(posedge clk)
    begin
        if (adv[3])
        begin
            side_reg <= side_next;
            nmag_reg <= nmag_next;
            dmag_reg <= dmag_next;
        end
    end

    assign out_valid   = vld_reg[NST-1];
    assign out_side    = side_reg;
    assign out_num_mag = nmag_reg;
    assign out_den_mag = dmag_reg;

endmodule

`default_nettype wire

@@ rtl/rdi_div.sv @@
// ============================================================================
// rdi_div
// restoring divider, one quotient bit per pipeline stage
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module rdi_div (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_ready,
    input  wire logic [52:0]         in_num_mag,
    input  wire logic [31:0]         in_den_mag,
    input  wire rdi_pkg::div_side_t  in_side,
    output logic                     out_valid,
    input  wire logic                out_ready,
    output logic [31:0]              out_quot,   // bit 31 set means quotient too large
    output rdi_pkg::div_side_t       out_side
);

    localparam int NST = 32;

    logic [NST-1:0] vld_reg;
    logic [NST-1:0] adv;
    logic [NST-1:0] vld_src;

    logic [52:0]        rem_reg  [NST];
    logic [31:0]        den_reg  [NST];
    logic [31:0]        quot_reg [NST];
    rdi_pkg::div_side_t side_reg [NST];

    logic [52:0]        rem_src  [NST];
    logic [31:0]        den_src  [NST];
    logic [31:0]        quot_src [NST];
    rdi_pkg::div_side_t side_src [NST];

    // ready chain
    assign adv[NST-1] = ~vld_reg[NST-1] | out_ready;
    assign vld_src    = {vld_reg[NST-2:0], in_valid};
    assign in_ready   = adv[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= (adv & vld_src) | (~adv & vld_reg);
        end
    end

    genvar j;
    generate
        for (j = 0; j < NST; j++) begin : g_stage
            logic [63:0] dsh;
            logic        ge;

            if (j == 0) begin : g_first
                assign rem_src[j]  = in_num_mag;
                assign den_src[j]  = in_den_mag;
                assign quot_src[j] = '0;
                assign side_src[j] = in_side;
            end
            else begin : g_next
                assign adv[j-1]    = ~vld_reg[j-1] | adv[j];
                assign rem_src[j]  = rem_reg[j-1];
                assign den_src[j]  = den_reg[j-1];
                assign quot_src[j] = quot_reg[j-1];
                assign side_src[j] = side_reg[j-1];
            end

            // trial subtract of the divisor aligned to this quotient bit
            assign dsh = 64'({den_src[j], 31'd0}) >> j;
            assign ge  = {11'd0, rem_src[j]} >= dsh;

            always_ff @(posedge clk)
            begin
                if (adv[j])
                begin
                    rem_reg[j]  <= ge ? 53'({11'd0, rem_src[j]} - dsh) : rem_src[j];
                    den_reg[j]  <= den_src[j];
                    quot_reg[j] <= quot_src[j] | (ge ? (32'd1 << (NST - 1 - j)) : 32'd0);
                    side_reg[j] <= side_src[j];
                end
            end
        end
    endgenerate

    assign out_valid = vld_reg[NST-1];
    assign out_quot  = quot_reg[NST-1];
    assign out_side  = side_reg[NST-1];

endmodule

`default_nettype wire

@@ rtl/rdi_back.sv @@
// ============================================================================
// rdi_back
// distance limits, hit point, radial distance test and result register
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module rdi_back #(
    parameter int FRAC_BITS = 16
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire rdi_pkg::cfg_t       cfg,
    input  wire logic                in_valid,
    output logic                     in_ready,
    input  wire logic [31:0]         in_quot,
    input  wire rdi_pkg::div_side_t  in_side,
    output logic                     out_valid,
    input  wire logic                out_ready,
    output logic                     hit,
    output logic [31:0]              distance,
    output logic [2:0][31:0]         point,
    output logic [2:0][17:0]         normal
);

    localparam int NST = 9;

    logic [NST-1:0] vld_reg;
    logic [NST-1:0] adv;
    logic [NST-1:0] vld_src;

    // carried per stage
    logic                miss_reg [NST-1];
    logic signed [31:0]  t_reg    [NST-1];
    rdi_pkg::ray_t       ray0_reg;
    logic [2:0][31:0]    org1_reg;
    logic [2:0][31:0]    p_reg    [2:7];
    logic signed [32:0]  v_reg    [2:5][3];

    logic signed [31:0]  t_next;
    logic                lim_ok;
    logic signed [63:0]  pdt_reg  [3];
    logic signed [63:0]  pdt_next [3];
    logic [2:0][31:0]    p_next;
    logic signed [32:0]  v_next   [3];
    logic signed [50:0]  pva_reg  [3];
    logic signed [50:0]  pva_next [3];
    logic signed [52:0]  sum_s;
    logic signed [52:0]  s_reg, s_next;
    logic signed [70:0]  pas_reg  [3];
    logic signed [70:0]  pas_next [3];
    logic signed [71:0]  w_full   [3];
    logic [31:0]         wm_reg   [3];
    logic [31:0]         wm_next  [3];
    logic [63:0]         sq_reg   [3];
    logic [63:0]         sq_next  [3];
    logic [65:0]         dist2;
    logic                on_cap;
    logic signed [18:0]  neg_axis [3];

    logic                hit_reg, hit_next;
    logic [31:0]         distance_reg, distance_next;
    logic [2:0][31:0]    point_reg, point_next;
    logic [2:0][17:0]    normal_reg, normal_next;

    // ready chain
    assign adv[NST-1] = ~vld_reg[NST-1] | out_ready;
    genvar k;
    generate
        for (k = 0; k < NST - 1; k++) begin : g_adv
            assign adv[k] = ~vld_reg[k] | adv[k+1];
        end
    endgenerate
    assign vld_src  = {vld_reg[NST-2:0], in_valid};
    assign in_ready = adv[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= (adv & vld_src) | (~adv & vld_reg);
        end
    end

    // stage 0: signed, saturated distance from the quotient
    always_comb
    begin
        if (in_quot[31])
        begin
            t_next = in_side.neg ? rdi_pkg::S32_MIN : rdi_pkg::S32_MAX;
        end
        else if (in_side.neg)
        begin
            t_next = -$signed({1'b0, in_quot[30:0]});
        end
        else
        begin
            t_next = $signed({1'b0, in_quot[30:0]});
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv[0])
        begin
            miss_reg[0] <= in_side.miss;
            t_reg[0]    <= t_next;
            ray0_reg    <= in_side.ray;
        end
    end

    // stage 1: limit test and direction times distance
    always_comb
    begin
        lim_ok = (t_reg[0] > $signed(ray0_reg.t_min)) && (t_reg[0] < $signed(ray0_reg.t_max));
        for (int i = 0; i < 3; i++)
        begin
            pdt_next[i] = $signed(ray0_reg.dir[i]) * t_reg[0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv[1])
        begin
            miss_reg[1] <= miss_reg[0] | ~lim_ok;
            t_reg[1]    <= t_reg[0];
            org1_reg    <= ray0_reg.org;
            for (int i = 0; i < 3; i++)
            begin
                pdt_reg[i] <= pdt_next[i];
            end
        end
    end

    // stage 2: hit point and offset from the center
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            p_next[i] = rdi_pkg::sat32(72'($signed(org1_reg[i])) + 72'(pdt_reg[i] >>> FRAC_BITS));
            v_next[i] = 33'($signed(p_next[i])) - 33'($signed(cfg.center[i]));
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv[2])
        begin
            miss_reg[2] <= miss_reg[1];
            t_reg[2]    <= t_reg[1];
            p_reg[2]    <= p_next;
            for (int i = 0; i < 3; i++)
            begin
                v_reg[2][i] <= v_next[i];
            end
        end
    end

    // stage 3: offset times axis
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            pva_next[i] = v_reg[2][i] * $signed(cfg.axis[i]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv[3])
        begin
            miss_reg[3] <= miss_reg[2];
            t_reg[3]    <= t_reg[2];
            p_reg[3]    <= p_reg[2];
            for (int i = 0; i < 3; i++)
            begin
                v_reg[3][i] <= v_reg[2][i];
                pva_reg[i]  <= pva_next[i];
            end
        end
    end

    // stage 4: projection onto the axis
    always_comb
    begin
        sum_s  = 53'(pva_reg[0]) + 53'(pva_reg[1]) + 53'(pva_reg[2]);
        s_next = sum_s >>> FRAC_BITS;
    end

    always_ff @(posedge clk)
    begin
        if (adv[4])
        begin
            miss_reg[4] <= miss_reg[3];
            t_reg[4]    <= t_reg[3];
            p_reg[4]    <= p_reg[3];
            s_reg       <= s_next;
            for (int i = 0; i < 3; i++)
            begin
                v_reg[4][i] <= v_reg[3][i];
            end
        end
    end

    // stage 5: axis scaled by the projection
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            pas_next[i] = $signed(cfg.axis[i]) * s_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv[5])
        begin
            miss_reg[5] <= miss_reg[4];
            t_reg[5]    <= t_reg[4];
            p_reg[5]    <= p_reg[4];
            for (int i = 0; i < 3; i++)
            begin
                v_reg[5][i] <= v_reg[4][i];
                pas_reg[i]  <= pas_next[i];
            end
        end
    end

    // stage 6: radial component, clamped to +-2^31, kept as a magnitude
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            w_full[i] = 72'(v_reg[5][i]) - 72'(pas_reg[i] >>> FRAC_BITS);
            if ((w_full[i] >= 72'sh8000_0000) || (w_full[i] <= -72'sh8000_0000))
            begin
                wm_next[i] = 32'h8000_0000;
            end
            else if (w_full[i][71])
            begin
                wm_next[i] = 32'(-w_full[i]);
            end
            else
            begin
                wm_next[i] = w_full[i][31:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv[6])
        begin
            miss_reg[6] <= miss_reg[5];
            t_reg[6]    <= t_reg[5];
            p_reg[6]    <= p_reg[5];
            for (int i = 0; i < 3; i++)
            begin
                wm_reg[i] <= wm_next[i];
            end
        end
    end

    // stage 7: squares
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            sq_next[i] = 64'(wm_reg[i]) * 64'(wm_reg[i]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv[7])
        begin
            miss_reg[7] <= miss_reg[6];
            t_reg[7]    <= t_reg[6];
            p_reg[7]    <= p_reg[6];
            for (int i = 0; i < 3; i++)
            begin
                sq_reg[i] <= sq_next[i];
            end
        end
    end

    // stage 8: radius test and result register
    always_comb
    begin
        dist2    = 66'(sq_reg[0]) + 66'(sq_reg[1]) + 66'(sq_reg[2]);
        on_cap   = dist2 <= 66'(cfg.lim);
        hit_next = ~miss_reg[7] & on_cap;
        for (int i = 0; i < 3; i++)
        begin
            neg_axis[i] = -19'($signed(cfg.axis[i]));
        end
        if (hit_next)
        begin
            distance_next = t_reg[7];
            point_next    = p_reg[7];
            for (int i = 0; i < 3; i++)
            begin
                // most negative axis negates past the top, pin it
                normal_next[i] = (neg_axis[i] == 19'sd131072) ? 18'sd131071 : neg_axis[i][17:0];
            end
        end
        else
        begin
            distance_next = rdi_pkg::S32_MAX;
            point_next    = '0;
            normal_next   = '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv[8])
        begin
            hit_reg      <= hit_next;
            distance_reg <= distance_next;
            point_reg    <= point_next;
            normal_reg   <= normal_next;
        end
    end

    assign out_valid = vld_reg[NST-1];
    assign hit       = hit_reg;
    assign distance  = distance_reg;
    assign point     = point_reg;
    assign normal    = normal_reg;

endmodule

`default_nettype wire

@@ rtl/ray_disk_intersect.sv @@
// ============================================================================
// ray_disk_intersect
// ray against flat circular cap, fully pipelined, signed fixed point
// ============================================================================
//  channel   direction  handshake             contents
//  s_axis    in         s_tvalid / s_tready   ray origin, direction, limits
//  m_axis    out        m_tvalid / m_tready   hit flag, distance, point, normal
//  cfg       in         cfg_valid / cfg_ready register index and write data
//
//  one ray per cycle sustained while the output is not stalled: 4 front stages, a
//  32-stage restoring divider (one quotient bit per stage) and 9 back stages
//  reset clears every stage valid bit and loads the default cap
//  a stalled output holds each stage in turn; nothing is dropped or repeated
//  configuration is accepted every cycle
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module ray_disk_intersect #(
    parameter int FRAC_BITS = 16
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire logic [255:0] s_tdata,  // origin_x, origin_y, origin_z, dir_x, dir_y,
                                        // dir_z, t_min, t_max
    output logic              m_tvalid,
    input  wire logic         m_tready,
    output logic [183:0]      m_tdata,  // distance, point_x, point_y, point_z,
                                        // normal_x, normal_y, normal_z, zero pad
    output logic [0:0]        m_tuser,  // hit
    input  wire logic         cfg_valid,
    output logic              cfg_ready,
    input  wire logic [2:0]   cfg_index,
    input  wire logic [31:0]  cfg_data
);

    // configuration registers
    logic [2:0][31:0] center_reg;
    logic [2:0][17:0] axis_reg;
    logic [30:0]      radius_reg;
    logic [15:0]      thr_reg;
    logic [62:0]      lim_reg, lim_next;
    rdi_pkg::cfg_t    cfg;

    rdi_pkg::ray_t      in_ray;
    logic               fr_valid, fr_ready;
    rdi_pkg::div_side_t fr_side;
    logic [52:0]        fr_num_mag;
    logic [31:0]        fr_den_mag;
    logic               dv_valid, dv_ready;
    logic [31:0]        dv_quot;
    rdi_pkg::div_side_t dv_side;
    logic               hit;
    logic [31:0]        distance;
    logic [2:0][31:0]   point;
    logic [2:0][17:0]   normal;

    assign cfg_ready = 1'b1;

    // register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            center_reg <= '0;
            axis_reg   <= {18'sd65536, 18'sd0, 18'sd0};
            radius_reg <= 31'd65536;
            thr_reg    <= 16'd1;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (rdi_pkg::reg_idx_t'(cfg_index))
                rdi_pkg::REG_CENTER_X: center_reg[0] <= cfg_data;
                rdi_pkg::REG_CENTER_Y: center_reg[1] <= cfg_data;
                rdi_pkg::REG_CENTER_Z: center_reg[2] <= cfg_data;
                rdi_pkg::REG_AXIS_X:   axis_reg[0]   <= cfg_data[17:0];
                rdi_pkg::REG_AXIS_Y:   axis_reg[1]   <= cfg_data[17:0];
                rdi_pkg::REG_AXIS_Z:   axis_reg[2]   <= cfg_data[17:0];
                rdi_pkg::REG_RADIUS:   radius_reg    <= cfg_data[30:0];
                rdi_pkg::REG_PAR_THR:  thr_reg       <= cfg_data[15:0];
                default:               thr_reg       <= thr_reg;
            endcase
        end
    end

    // squared radius plus one lsb, refreshed every cycle
    assign lim_next = 63'(radius_reg) * 63'(radius_reg) + (63'd1 << FRAC_BITS);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lim_reg <= (63'd65536 * 63'd65536) + (63'd1 << FRAC_BITS);
        end
        else
        begin
            lim_reg <= lim_next;
        end
    end

    assign cfg.center  = center_reg;
    assign cfg.axis    = axis_reg;
    assign cfg.par_thr = thr_reg;
    assign cfg.lim     = lim_reg;

    // unpack the input transaction
    assign in_ray.org[0] = s_tdata[31:0];
    assign in_ray.org[1] = s_tdata[63:32];
    assign in_ray.org[2] = s_tdata[95:64];
    assign in_ray.dir[0] = s_tdata[127:96];
    assign in_ray.dir[1] = s_tdata[159:128];
    assign in_ray.dir[2] = s_tdata[191:160];
    assign in_ray.t_min  = s_tdata[223:192];
    assign in_ray.t_max  = s_tdata[255:224];

    rdi_front #(
        .FRAC_BITS (FRAC_BITS)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg),
        .in_valid    (s_tvalid),
        .in_ready    (s_tready),
        .in_ray      (in_ray),
        .out_valid   (fr_valid),
        .out_ready   (fr_ready),
        .out_side    (fr_side),
        .out_num_mag (fr_num_mag),
        .out_den_mag (fr_den_mag)
    );

    rdi_div u_div (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (fr_valid),
        .in_ready   (fr_ready),
        .in_num_mag (fr_num_mag),
        .in_den_mag (fr_den_mag),
        .in_side    (fr_side),
        .out_valid  (dv_valid),
        .out_ready  (dv_ready),
        .out_quot   (dv_quot),
        .out_side   (dv_side)
    );

    rdi_back #(
        .FRAC_BITS (FRAC_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .in_valid  (dv_valid),
        .in_ready  (dv_ready),
        .in_quot   (dv_quot),
        .in_side   (dv_side),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .hit       (hit),
        .distance  (distance),
        .point     (point),
        .normal    (normal)
    );

    // pack the result transaction
    assign m_tdata = {2'b00, normal[2], normal[1], normal[0],
                      point[2], point[1], point[0], distance};
    assign m_tuser = hit;

`include "ray_disk_intersect_macros.svh"

    // a hit lies strictly below t_max, so never at the miss code
    `RDI_ASSERT_SAME(a_hit_distance, m_tvalid && m_tuser[0], m_tdata[31:0] != 32'h7FFF_FFFF, "hit carries the miss distance")
    // a miss carries only the saturated distance
    `RDI_ASSERT_SAME(a_miss_zero, m_tvalid && !m_tuser[0], (m_tdata[31:0] == 32'h7FFF_FFFF) && (m_tdata[183:32] == '0), "miss result not cleared")
    // input backpressure only comes from a stalled full pipeline
    `RDI_ASSERT_SAME(a_stall_source, !s_tready, m_tvalid && !m_tready, "input stalled without output stall")

endmodule

`default_nettype wire
